>>> hw/rtl/tsr_pkg.sv
// Shared types, codes and helper functions for the tile and sprite pixel renderer.
package tsr_pkg;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] REQ_VRAM_WR   = 2'd0;
   localparam logic [1:0] REQ_SPRITE_WR = 2'd1;
   localparam logic [1:0] REQ_RENDER    = 2'd2;

   // Pixel source codes carried on rsp_tuser.
   localparam logic [1:0] SRC_OFF    = 2'd0;
   localparam logic [1:0] SRC_BG     = 2'd1;
   localparam logic [1:0] SRC_WINDOW = 2'd2;
   localparam logic [1:0] SRC_SPRITE = 2'd3;

   // Configuration register indexes.
   localparam logic [2:0] REG_LCDC  = 3'd0;
   localparam logic [2:0] REG_SCY   = 3'd1;
   localparam logic [2:0] REG_SCX   = 3'd2;
   localparam logic [2:0] REG_WY    = 3'd3;
   localparam logic [2:0] REG_WX    = 3'd4;
   localparam logic [2:0] REG_BGP   = 3'd5;
   localparam logic [2:0] REG_OBP0  = 3'd6;
   localparam logic [2:0] REG_OBP1  = 3'd7;

   // Register reset values.
   localparam logic [7:0] LCDC_RESET = 8'h91;
   localparam logic [7:0] BGP_RESET  = 8'hFC;
   localparam logic [7:0] OBP_RESET  = 8'hFF;

   // Window visibility limits.
   localparam logic [7:0] WY_LIMIT = 8'd143;
   localparam logic [7:0] WX_LIMIT = 8'd166;

   // Sprite attribute table size in bytes.
   localparam logic [7:0] TABLE_BYTES = 8'd160;

   // One sprite's scan record, loaded from its cell and shifted along the chain.
   typedef struct packed {
      logic        hit;
      logic [11:0] line;
      logic [2:0]  col;
      logic        pal;
      logic        prio;
   } scan_rec_type;

   // Shade taken from a palette by a 2-bit raw value.
   function automatic logic [1:0] pal_shade(input logic [7:0] pal, input logic [1:0] raw);
      logic [1:0] s;
      case (raw)
         2'd0:    s = pal[1:0];
         2'd1:    s = pal[3:2];
         2'd2:    s = pal[5:4];
         default: s = pal[7:6];
      endcase
      return s;
   endfunction

   // Grey level for a shade, white at zero.
   function automatic logic [23:0] shade_rgb(input logic [1:0] shade);
      logic [23:0] c;
      case (shade)
         2'd0:    c = 24'hFFFFFF;
         2'd1:    c = 24'hAAAAAA;
         2'd2:    c = 24'h555555;
         default: c = 24'h000000;
      endcase
      return c;
   endfunction

endpackage

>>> hw/rtl/tsr_vram.sv
// Video RAM: one write port and one registered read port.
module tsr_vram (
   input  logic        clock,
   input  logic        wr_en,
   input  logic [12:0] wr_addr,
   input  logic [7:0]  wr_data,
   input  logic [12:0] rd_addr,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [8192];
   logic [7:0] rd_data_ff;

   // Write and read in one clocked block; read data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/tsr_sprite_cell.sv
// One sprite cell: holds four attribute bytes and one stage of the scan chain.
module tsr_sprite_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  attr_wr,
   input  logic [1:0]            attr_sel,
   input  logic [7:0]            attr_data,
   input  logic [7:0]            pixel_x,
   input  logic [7:0]            pixel_y,
   input  logic                  load,
   input  logic                  shift,
   input  tsr_pkg::scan_rec_type rec_next,
   output tsr_pkg::scan_rec_type rec
);

   logic [7:0] pos_y_ff, pos_x_ff, tile_ff, flags_ff;
   logic [9:0] dy, dx;
   logic [2:0] ty, tx;
   tsr_pkg::scan_rec_type rec_ff, rec_in;

   // Attribute bytes, written by sprite table beats.
   always_ff @(posedge clock) begin
      if (attr_wr) begin
         case (attr_sel)
            2'd0:    pos_y_ff <= attr_data;
            2'd1:    pos_x_ff <= attr_data;
            2'd2:    tile_ff  <= attr_data;
            default: flags_ff <= attr_data;
         endcase
      end
   end

   // Offset of the point inside the sprite; a hit leaves only the low three bits.
   assign dy = {2'b00, pixel_y} + 10'd16 - {2'b00, pos_y_ff};
   assign dx = {2'b00, pixel_x} + 10'd8 - {2'b00, pos_x_ff};
   assign ty = flags_ff[6] ? ~dy[2:0] : dy[2:0];
   assign tx = flags_ff[5] ? ~dx[2:0] : dx[2:0];

   // Load from own attributes, or take the neighbour's record.
   always_comb begin
      rec_in = rec_ff;
      if (load) begin
         rec_in.hit  = (dy[9:3] == 7'd0) && (dx[9:3] == 7'd0);
         rec_in.line = {tile_ff, ty, 1'b0};
         rec_in.col  = tx;
         rec_in.pal  = flags_ff[4];
         rec_in.prio = flags_ff[7];
      end else if (shift) begin
         rec_in = rec_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff <= '0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign rec = rec_ff;

endmodule

>>> hw/rtl/tile_sprite_pixel_renderer.sv
// Top level of the tile and sprite pixel renderer: registers, sequencer and sprite chain.
//
//  Channel | Direction | Beat contents
//  req     | in        | tuser: req_type; tdata: mem_addr, mem_data, pixel_x, pixel_y
//  rsp     | out       | tuser: source; tdata: shade, rgb_color
//  csr     | in/out    | eight 8-bit registers at byte addresses 0, 4, ..., 28
//
// All request beats are taken only in an idle cycle. A render beat then passes the map,
// low, high and pixel states for each layer fetched (background, then window), a chain
// load state, a head state per sprite examined plus low and high states per sprite under
// the point, and a finishing state; all reads share the single video RAM read port.
// The finishing state repeats while the output register still holds an unaccepted beat.
// Reset is synchronous; video RAM and sprite attributes are not cleared.
// A waiting result in the output register does not block memory write beats.
module tile_sprite_pixel_renderer #(
   parameter int SPRITE_COUNT = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   input  logic [39:0] req_tdata,   // [12:0] mem_addr, [20:13] mem_data, [28:21] pixel_x,
                                    // [36:29] pixel_y, [39:37] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [1:0]  rsp_tuser,   // [1:0] source
   output logic [31:0] rsp_tdata,   // [1:0] shade, [25:2] rgb_color, [31:26] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CNT_W = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SPRITE_COUNT - 1);

   // Sequencer states.
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_MAP     = 4'd1;
   localparam logic [3:0] ST_LO      = 4'd2;
   localparam logic [3:0] ST_HI      = 4'd3;
   localparam logic [3:0] ST_PIX     = 4'd4;
   localparam logic [3:0] ST_SP_LOAD = 4'd5;
   localparam logic [3:0] ST_SP_HEAD = 4'd6;
   localparam logic [3:0] ST_SP_LO   = 4'd7;
   localparam logic [3:0] ST_SP_HI   = 4'd8;
   localparam logic [3:0] ST_FIN     = 4'd9;

   logic [7:0] lcdc_ff, scy_ff, scx_ff, wy_ff, wx_ff, bgp_ff, obp0_ff, obp1_ff;
   logic       csr_wr;

   logic [3:0] state_ff, state_in;
   logic       layer_ff, layer_in;
   logic [7:0] x_ff, y_ff;
   logic [1:0] raw_ff, raw_in, shade_ff, shade_in, src_ff, src_in;
   logic [7:0] lo_ff, lo_in;
   logic [12:0] line_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff;
   logic [1:0] rsp_shade_ff, rsp_src_ff;

   logic        req_acc;
   logic [1:0]  req_type;
   logic [12:0] mem_addr;
   logic [7:0]  mem_data;
   logic [12:0] rd_addr;
   logic [7:0]  rd_data;
   logic [8:0]  wx_sum;
   logic        win_on;
   logic [7:0]  mx, my;
   logic [12:0] tile_base, line_addr;
   logic [1:0]  pix, sp_pix;
   logic        chain_load, chain_shift;

   tsr_pkg::scan_rec_type recs [SPRITE_COUNT];
   tsr_pkg::scan_rec_type head;

   assign req_type = req_tuser;
   assign mem_addr = req_tdata[12:0];
   assign mem_data = req_tdata[20:13];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc = req_tvalid && req_tready;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lcdc_ff <= tsr_pkg::LCDC_RESET;
         scy_ff  <= '0;
         scx_ff  <= '0;
         wy_ff   <= '0;
         wx_ff   <= '0;
         bgp_ff  <= tsr_pkg::BGP_RESET;
         obp0_ff <= tsr_pkg::OBP_RESET;
         obp1_ff <= tsr_pkg::OBP_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            tsr_pkg::REG_LCDC: lcdc_ff <= csr_pwdata[7:0];
            tsr_pkg::REG_SCY:  scy_ff  <= csr_pwdata[7:0];
            tsr_pkg::REG_SCX:  scx_ff  <= csr_pwdata[7:0];
            tsr_pkg::REG_WY:   wy_ff   <= csr_pwdata[7:0];
            tsr_pkg::REG_WX:   wx_ff   <= csr_pwdata[7:0];
            tsr_pkg::REG_BGP:  bgp_ff  <= csr_pwdata[7:0];
            tsr_pkg::REG_OBP0: obp0_ff <= csr_pwdata[7:0];
            default:           obp1_ff <= csr_pwdata[7:0];
         endcase
      end
   end

   // Register read-back.
   always_comb begin
      unique case (csr_paddr[4:2])
         tsr_pkg::REG_LCDC: csr_prdata = {24'd0, lcdc_ff};
         tsr_pkg::REG_SCY:  csr_prdata = {24'd0, scy_ff};
         tsr_pkg::REG_SCX:  csr_prdata = {24'd0, scx_ff};
         tsr_pkg::REG_WY:   csr_prdata = {24'd0, wy_ff};
         tsr_pkg::REG_WX:   csr_prdata = {24'd0, wx_ff};
         tsr_pkg::REG_BGP:  csr_prdata = {24'd0, bgp_ff};
         tsr_pkg::REG_OBP0: csr_prdata = {24'd0, obp0_ff};
         default:           csr_prdata = {24'd0, obp1_ff};
      endcase
   end

   // Video RAM.
   tsr_vram u_vram (
      .clock   (clock),
      .wr_en   (req_acc && (req_type == tsr_pkg::REQ_VRAM_WR)),
      .wr_addr (mem_addr),
      .wr_data (mem_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sprite chain: cell 0 is the head that the sequencer examines.
   genvar gi;
   generate
      for (gi = 0; gi < SPRITE_COUNT; gi++) begin : g_cell
         tsr_pkg::scan_rec_type nxt;
         if (gi == SPRITE_COUNT - 1) begin : g_end
            assign nxt = '0;
         end else begin : g_mid
            assign nxt = recs[gi+1];
         end
         tsr_sprite_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .attr_wr   (req_acc && (req_type == tsr_pkg::REQ_SPRITE_WR)
                        && (mem_addr < {5'd0, tsr_pkg::TABLE_BYTES})
                        && (mem_addr[7:2] == 6'(gi))),
            .attr_sel  (mem_addr[1:0]),
            .attr_data (mem_data),
            .pixel_x   (x_ff),
            .pixel_y   (y_ff),
            .load      (chain_load),
            .shift     (chain_shift),
            .rec_next  (nxt),
            .rec       (recs[gi])
         );
      end
   endgenerate

   assign head = recs[0];

   // Window placement and visibility.
   assign wx_sum = {1'b0, x_ff} + 9'd7 - {1'b0, wx_ff};
   assign win_on = lcdc_ff[5] && (wy_ff <= tsr_pkg::WY_LIMIT) && (wx_ff <= tsr_pkg::WX_LIMIT)
                   && ({1'b0, x_ff} + 9'd7 >= {1'b0, wx_ff}) && (y_ff >= wy_ff);

   // Map coordinates of the layer being fetched.
   always_comb begin
      if (layer_ff) begin
         mx = wx_sum[7:0];
         my = y_ff - wy_ff;
      end else begin
         mx = x_ff + scx_ff;
         my = y_ff + scy_ff;
      end
   end

   // Tile data base from the fetched tile number, in unsigned or signed mode.
   assign tile_base = lcdc_ff[4] ? {1'b0, rd_data, 4'd0}
                                 : 13'h0800 + {1'b0, rd_data ^ 8'h80, 4'd0};
   assign line_addr = tile_base | {8'd0, my[2:0], 1'b0};
   assign pix = {rd_data[~mx[2:0]], lo_ff[~mx[2:0]]};
   assign sp_pix = {rd_data[~head.col], lo_ff[~head.col]};

   // Sequencer.
   always_comb begin
      state_in    = state_ff;
      layer_in    = layer_ff;
      raw_in      = raw_ff;
      shade_in    = shade_ff;
      src_in      = src_ff;
      lo_in       = lo_ff;
      cnt_in      = cnt_ff;
      rd_addr     = '0;
      chain_load  = 1'b0;
      chain_shift = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            layer_in = 1'b0;
            raw_in   = '0;
            shade_in = '0;
            src_in   = tsr_pkg::SRC_OFF;
            if (req_acc && (req_type == tsr_pkg::REQ_RENDER)) begin
               state_in = lcdc_ff[0] ? ST_MAP : ST_SP_LOAD;
            end
         end
         ST_MAP: begin
            rd_addr  = {2'b11, layer_ff ? lcdc_ff[6] : lcdc_ff[3], my[7:3], mx[7:3]};
            state_in = ST_LO;
         end
         ST_LO: begin
            rd_addr  = line_addr;
            state_in = ST_HI;
         end
         ST_HI: begin
            lo_in    = rd_data;
            rd_addr  = {line_ff[12:1], 1'b1};
            state_in = ST_PIX;
         end
         ST_PIX: begin
            raw_in   = raw_ff | pix;
            shade_in = tsr_pkg::pal_shade(bgp_ff, pix);
            src_in   = layer_ff ? tsr_pkg::SRC_WINDOW : tsr_pkg::SRC_BG;
            if (!layer_ff && win_on) begin
               layer_in = 1'b1;
               state_in = ST_MAP;
            end else begin
               state_in = ST_SP_LOAD;
            end
         end
         ST_SP_LOAD: begin
            cnt_in = '0;
            if (lcdc_ff[1]) begin
               chain_load = 1'b1;
               state_in   = ST_SP_HEAD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_SP_HEAD: begin
            rd_addr = {1'b0, head.line};
            if (head.hit) begin
               state_in = ST_SP_LO;
            end else begin
               chain_shift = 1'b1;
               cnt_in      = cnt_ff + CNT_W'(1);
               state_in    = (cnt_ff == CNT_LAST) ? ST_FIN : ST_SP_HEAD;
            end
         end
         ST_SP_LO: begin
            lo_in    = rd_data;
            rd_addr  = {1'b0, head.line[11:1], 1'b1};
            state_in = ST_SP_HI;
         end
         ST_SP_HI: begin
            if (sp_pix != 2'd0) begin
               if (!head.prio || (raw_ff == 2'd0)) begin
                  shade_in = tsr_pkg::pal_shade(head.pal ? obp1_ff : obp0_ff, sp_pix);
                  src_in   = tsr_pkg::SRC_SPRITE;
               end
               state_in = ST_FIN;
            end else begin
               chain_shift = 1'b1;
               cnt_in      = cnt_ff + CNT_W'(1);
               state_in    = (cnt_ff == CNT_LAST) ? ST_FIN : ST_SP_HEAD;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The tile line address is kept for the high byte read of a layer.
   always_ff @(posedge clock) begin
      if (state_ff == ST_LO) begin
         line_ff <= line_addr;
      end
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         layer_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         layer_ff <= layer_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff   <= raw_in;
      shade_ff <= shade_in;
      src_ff   <= src_in;
      lo_ff    <= lo_in;
      if (req_acc) begin
         x_ff <= req_tdata[28:21];
         y_ff <= req_tdata[36:29];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_tready)) begin
         rsp_shade_ff <= shade_ff;
         rsp_src_ff   <= src_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_src_ff;
   assign rsp_tdata  = {6'd0, tsr_pkg::shade_rgb(rsp_shade_ff), rsp_shade_ff};

   // A sprite pixel is only evaluated for a sprite under the point.
   a_sp_hit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SP_HI) |-> head.hit)
      else $error("sprite pixel evaluated without a hit");

   // While scanning, the counter stays within the sprite count.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SP_HEAD) |-> (cnt_ff <= CNT_LAST))
      else $error("sprite scan counter out of range");

   // A new result appears only after the sequencer finished an item.
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN))
      else $error("result shown without a finished item");

endmodule

>>> verif/tile_sprite_pixel_renderer_tb.sv
// Self-checking testbench for the tile and sprite pixel renderer.
module tile_sprite_pixel_renderer_tb;

   typedef struct {
      logic [1:0]  shade;
      logic [23:0] rgb;
      logic [1:0]  src;
   } pixel_type;

   // Request kind that the block ignores.
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = '0;   // [1:0] req_type
   logic [39:0] req_tdata = '0;   // [12:0] mem_addr, [20:13] mem_data, [28:21] pixel_x,
                                  // [36:29] pixel_y, [39:37] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [1:0]  rsp_tuser;        // [1:0] source
   logic [31:0] rsp_tdata;        // [1:0] shade, [25:2] rgb_color, [31:26] zero
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Mirror of the block's memories and registers, with a written mark per video RAM byte.
   logic [7:0] vram [0:8191];
   bit         vram_ok [0:8191];
   logic [7:0] oam [0:159];
   logic [7:0] reg_val [0:7];

   pixel_type pixel_q [$];
   int mismatches = 0;
   bit no_gaps = 1'b0;
   int stall_left = 0;
   int gap_addr = -1;

   tile_sprite_pixel_renderer u_top (.*);

   always #4 clock = ~clock;

   // Mirror read that notes the first byte touched before it was ever written.
   function automatic logic [7:0] vram_rd(int a);
      int i;
      i = a & 8191;
      if (!vram_ok[i] && gap_addr < 0) gap_addr = i;
      return vram[i];
   endfunction

   // Raw value of one pixel of the tile whose data starts at off.
   function automatic int tile_raw(int off, int row, int col);
      int line;
      int sh;
      logic [7:0] lo;
      logic [7:0] hi;
      line = off + 2 * (row & 7);
      sh = 7 - (col & 7);
      lo = vram_rd(line);
      hi = vram_rd(line + 1);
      return int'(lo[sh]) | (int'(hi[sh]) << 1);
   endfunction

   function automatic int map_raw(int map_off, int mx, int my);
      int tile;
      int data;
      tile = vram_rd(map_off + 32 * ((my >> 3) & 31) + ((mx >> 3) & 31));
      if (reg_val[tsr_pkg::REG_LCDC][4]) data = tile * 16;
      else data = 'h800 + ((tile + 128) & 255) * 16;
      return tile_raw(data, my, mx);
   endfunction

   function automatic logic [1:0] shade_of(logic [7:0] pal, int raw);
      return 2'((pal >> (2 * (raw & 3))) & 3);
   endfunction

   // Expected pixel for a render beat at (px, py).
   function automatic pixel_type render_pixel(logic [7:0] px, logic [7:0] py);
      pixel_type r;
      int raw;
      int wraw;
      int x;
      int y;
      int wx;
      int wy;
      int top;
      int left;
      int tx;
      int ty;
      int p;
      bit found;
      logic [7:0] lcdc;
      logic [7:0] attr;
      x = px;
      y = py;
      lcdc = reg_val[tsr_pkg::REG_LCDC];
      raw = 0;
      r.shade = 2'd0;
      r.src = tsr_pkg::SRC_OFF;
      found = 1'b0;
      // Background, then the window laid over it.
      if (lcdc[0]) begin
         raw = map_raw(lcdc[3] ? 'h1C00 : 'h1800, (x + reg_val[tsr_pkg::REG_SCX]) & 255,
                       (y + reg_val[tsr_pkg::REG_SCY]) & 255);
         r.shade = shade_of(reg_val[tsr_pkg::REG_BGP], raw);
         r.src = tsr_pkg::SRC_BG;
         if (lcdc[5] && reg_val[tsr_pkg::REG_WY] <= 143 && reg_val[tsr_pkg::REG_WX] <= 166)
         begin
            wx = x - (int'(reg_val[tsr_pkg::REG_WX]) - 7);
            wy = y - int'(reg_val[tsr_pkg::REG_WY]);
            if (wx >= 0 && wy >= 0) begin
               wraw = map_raw(lcdc[6] ? 'h1C00 : 'h1800, wx, wy);
               r.shade = shade_of(reg_val[tsr_pkg::REG_BGP], wraw);
               r.src = tsr_pkg::SRC_WINDOW;
               raw = raw | wraw;
            end
         end
      end
      // Sprites in table order; the first nonzero pixel decides.
      if (lcdc[1]) begin
         for (int s = 0; s < 40; s++) begin
            if (!found) begin
               top = int'(oam[4 * s]) - 16;
               left = int'(oam[4 * s + 1]) - 8;
               attr = oam[4 * s + 3];
               if (y >= top && y < top + 8 && x >= left && x < left + 8) begin
                  tx = x - left;
                  ty = y - top;
                  if (attr[5]) tx = 7 - tx;
                  if (attr[6]) ty = 7 - ty;
                  p = tile_raw(int'(oam[4 * s + 2]) * 16, ty, tx);
                  if (p != 0) begin
                     found = 1'b1;
                     if (!attr[7] || raw == 0) begin
                        r.shade = shade_of(attr[4] ? reg_val[tsr_pkg::REG_OBP1]
                                                   : reg_val[tsr_pkg::REG_OBP0], p);
                        r.src = tsr_pkg::SRC_SPRITE;
                     end
                  end
               end
            end
         end
      end
      r.rgb = 24'hFFFFFF - 24'(r.shade) * 24'h555555;
      return r;
   endfunction

   function automatic int gap_len();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(15);
      if (r < 8) return 0;
      if (r < 14) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Send one request beat and update the mirror once it is accepted.
   task automatic send_beat(logic [1:0] kind, logic [12:0] addr, logic [7:0] data,
                            logic [7:0] px, logic [7:0] py);
      int gap;
      bit rdy;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {3'b000, py, px, data, addr};
      forever begin
         @(negedge clock);
         rdy = req_tready;
         @(posedge clock);
         if (rdy) break;
      end
      case (kind)
         tsr_pkg::REQ_VRAM_WR: begin
            vram[addr] = data;
            vram_ok[addr] = 1'b1;
         end
         tsr_pkg::REQ_SPRITE_WR: if (addr < 160) oam[addr] = data;
         tsr_pkg::REQ_RENDER: pixel_q.push_back(render_pixel(px, py));
         default: ;
      endcase
   endtask

   // Render one point, first writing every video RAM byte it would read unwritten.
   task automatic send_render(logic [7:0] px, logic [7:0] py);
      forever begin
         gap_addr = -1;
         void'(render_pixel(px, py));
         if (gap_addr < 0) break;
         send_beat(tsr_pkg::REQ_VRAM_WR, 13'(gap_addr), 8'($urandom), 8'd0, 8'd0);
      end
      send_beat(tsr_pkg::REQ_RENDER, 13'($urandom), 8'($urandom), px, py);
   endtask

   // Wait until every expected pixel has come.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      reg_val[idx] = value;
   endtask

   task automatic write_all(logic [7:0] lcdc, logic [7:0] scy, logic [7:0] scx,
                            logic [7:0] wy, logic [7:0] wx);
      csr_write(tsr_pkg::REG_LCDC, lcdc);
      csr_write(tsr_pkg::REG_SCY, scy);
      csr_write(tsr_pkg::REG_SCX, scx);
      csr_write(tsr_pkg::REG_WY, wy);
      csr_write(tsr_pkg::REG_WX, wx);
      csr_write(tsr_pkg::REG_BGP, 8'($urandom));
      csr_write(tsr_pkg::REG_OBP0, 8'($urandom));
      csr_write(tsr_pkg::REG_OBP1, 8'($urandom));
   endtask

   task automatic render_any();
      if ($urandom_range(9) == 0)
         send_render(8'($urandom), 8'($urandom));
      else
         send_render(8'($urandom_range(159)), 8'($urandom_range(143)));
   endtask

   // Fill the whole sprite table; video RAM is written as renders need it.
   task automatic test_memory_fill();
      no_gaps = 1'b1;
      for (int a = 0; a < 160; a++) begin
         if (a % 4 == 0)
            send_beat(tsr_pkg::REQ_SPRITE_WR, 13'(a), 8'($urandom_range(160, 16)), 8'd0, 8'd0);
         else if (a % 4 == 1)
            send_beat(tsr_pkg::REQ_SPRITE_WR, 13'(a), 8'($urandom_range(168, 8)), 8'd0, 8'd0);
         else
            send_beat(tsr_pkg::REQ_SPRITE_WR, 13'(a), 8'($urandom), 8'd0, 8'd0);
      end
      no_gaps = 1'b0;
   endtask

   // Corners, off-screen points, ignored writes and the unknown request.
   task automatic test_directed();
      send_render(8'd0, 8'd0);
      send_render(8'd159, 8'd143);
      send_render(8'd255, 8'd255);
      send_beat(tsr_pkg::REQ_SPRITE_WR, 13'd160, 8'hAA, 8'd0, 8'd0);
      send_beat(tsr_pkg::REQ_SPRITE_WR, 13'h1FFF, 8'h55, 8'd0, 8'd0);
      send_beat(tsr_pkg::REQ_SPRITE_WR, 13'd159, 8'hF0, 8'd0, 8'd0);
      send_beat(tsr_pkg::REQ_VRAM_WR, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF);
      send_beat(REQ_UNKNOWN, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF);
      // Sprite zero over the top-left corner with both flips and priority.
      send_beat(tsr_pkg::REQ_SPRITE_WR, 13'd0, 8'd16, 8'd0, 8'd0);
      send_beat(tsr_pkg::REQ_SPRITE_WR, 13'd1, 8'd8, 8'd0, 8'd0);
      send_beat(tsr_pkg::REQ_SPRITE_WR, 13'd3, 8'hF0, 8'd0, 8'd0);
      for (int i = 0; i < 4; i++)
         send_render(8'(i * 2), 8'(i * 2 + 1));
      send_beat(tsr_pkg::REQ_SPRITE_WR, 13'd3, 8'h00, 8'd0, 8'd0);
      send_render(8'd3, 8'd4);
      drain();
   endtask

   // Layer enables and window limits at their extremes.
   task automatic test_layers();
      write_all(8'h00, 8'd0, 8'd0, 8'd0, 8'd0);
      repeat (4) render_any();
      drain();
      write_all(8'hFF, 8'hFF, 8'hFF, 8'd0, 8'd7);
      repeat (4) render_any();
      drain();
      write_all(8'h6F, 8'd0, 8'd0, 8'd143, 8'd166);
      send_render(8'd159, 8'd143);
      send_render(8'd158, 8'd142);
      drain();
      write_all(8'h21, 8'd0, 8'd0, 8'd144, 8'd167);
      repeat (3) render_any();
      drain();
      write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      repeat (3) render_any();
      drain();
   endtask

   // Random beats over several register settings.
   task automatic test_random();
      int r;
      for (int phase = 0; phase < 4; phase++) begin
         write_all(8'($urandom) | 8'h01, 8'($urandom), 8'($urandom),
                   8'($urandom_range(150)), 8'($urandom_range(175)));
         for (int i = 0; i < 30; i++) begin
            r = $urandom_range(99);
            if (r < 55) render_any();
            else if (r < 75)
               send_beat(tsr_pkg::REQ_SPRITE_WR, 13'($urandom_range(170)), 8'($urandom),
                         8'd0, 8'd0);
            else if (r < 97)
               send_beat(tsr_pkg::REQ_VRAM_WR, 13'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
            else send_beat(REQ_UNKNOWN, 13'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom));
            // Hold the sender until the pipeline is empty.
            if (i == 15 && phase == 2) begin
               req_tvalid <= 1'b0;
               while (pixel_q.size() != 0) @(posedge clock);
            end
         end
         drain();
      end
   endtask

   // Result side stalls: mostly short, a few long, some quiet stretches.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!no_gaps && $urandom_range(7) == 0) begin
         stall_left <= ($urandom_range(9) == 0) ? $urandom_range(50, 15) : $urandom_range(3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare each accepted result beat with the oldest expected pixel.
   always @(negedge clock) begin
      pixel_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            if (mismatches < 10) $display("unexpected result beat: %h %h", rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            e = pixel_q.pop_front();
            if (rsp_tdata[1:0] !== e.shade || rsp_tdata[25:2] !== e.rgb || rsp_tuser !== e.src)
            begin
               if (mismatches < 10)
                  $display("pixel mismatch: expected shade %0d rgb %h src %0d, got %0d %h %0d",
                           e.shade, e.rgb, e.src, rsp_tdata[1:0], rsp_tdata[25:2], rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   initial begin
      reg_val[tsr_pkg::REG_LCDC] = tsr_pkg::LCDC_RESET;
      reg_val[tsr_pkg::REG_SCY] = 8'd0;
      reg_val[tsr_pkg::REG_SCX] = 8'd0;
      reg_val[tsr_pkg::REG_WY] = 8'd0;
      reg_val[tsr_pkg::REG_WX] = 8'd0;
      reg_val[tsr_pkg::REG_BGP] = tsr_pkg::BGP_RESET;
      reg_val[tsr_pkg::REG_OBP0] = tsr_pkg::OBP_RESET;
      reg_val[tsr_pkg::REG_OBP1] = tsr_pkg::OBP_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_memory_fill();
      test_directed();
      test_layers();
      test_random();
      drain();
      if (mismatches == 0 && pixel_q.size() == 0)
         $display("tile_sprite_pixel_renderer verification clean");
      else
         $display("tile_sprite_pixel_renderer verification failed");
      $finish;
   end

   // Overall time limit.
   initial begin
      #8000000;
      $display("tile_sprite_pixel_renderer verification failed");
      $finish;
   end

endmodule
